### sv/rrts_pkg.sv
// shared constants, command codes and queue entry type of the round-robin task scheduler
package rrts_pkg;

  localparam int MAX_TASKS   = 16;
  localparam int SLOT_W      = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W       = $clog2(MAX_TASKS + 1);
  localparam int ID_W        = 5;
  localparam int OP_W        = 3;
  localparam int STAT_W      = 2;
  localparam int XV_W        = 32;
  localparam int CMP_W       = (CNT_W > ID_W) ? CNT_W : ID_W;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [OP_W-1:0] OP_CREATE = 3'd0;
  localparam logic [OP_W-1:0] OP_START  = 3'd1;
  localparam logic [OP_W-1:0] OP_TICK   = 3'd2;
  localparam logic [OP_W-1:0] OP_BLOCK  = 3'd3;
  localparam logic [OP_W-1:0] OP_WAKE   = 3'd4;
  localparam logic [OP_W-1:0] OP_KILL   = 3'd5;
  localparam logic [OP_W-1:0] OP_WAIT   = 3'd6;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd1;
  localparam logic [STAT_W-1:0] ST_BLOCKED  = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd3;

  localparam logic [1:0] TS_READY      = 2'd0;
  localparam logic [1:0] TS_RUNNING    = 2'd1;
  localparam logic [1:0] TS_BLOCKED    = 2'd2;
  localparam logic [1:0] TS_TERMINATED = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]        op;
    logic [ID_W-1:0]        task_id;
    logic                   id_nz;
    logic [SLOT_W-1:0]      slot;
    logic signed [XV_W-1:0] exit_value;
  } cmd_t;

  function automatic logic [SLOT_W-1:0] first_set(input logic [MAX_TASKS-1:0] v);
    logic [SLOT_W-1:0] idx;
    idx = '0;
    for (int i = MAX_TASKS - 1; i >= 0; i--) begin
      if (v[i]) idx = SLOT_W'(i);
    end
    return idx;
  endfunction

endpackage

### sv/rrts_front.sv
// front end: accepts commands and decodes them into queue entries
module rrts_front (
  input  logic                           start_i,
  input  logic                           full_i,
  input  logic [rrts_pkg::OP_W-1:0]      op_i,
  input  logic [rrts_pkg::ID_W-1:0]      task_id_i,
  input  logic signed [rrts_pkg::XV_W-1:0] exit_value_i,
  output logic                           busy_o,
  output logic                           push_o,
  output rrts_pkg::cmd_t                 entry_o
);
  import rrts_pkg::*;

  logic [CMP_W-1:0] id_m1;

  assign busy_o = full_i;
  assign push_o = start_i && !full_i;
  assign id_m1  = CMP_W'(task_id_i) - CMP_W'(1);

  always_comb begin
    entry_o.op         = op_i;
    entry_o.task_id    = task_id_i;
    entry_o.id_nz      = (task_id_i != '0);
    entry_o.slot       = id_m1[SLOT_W-1:0];
    entry_o.exit_value = exit_value_i;
  end

endmodule

### sv/rrts_queue.sv
// short command queue between front and back
module rrts_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  rrts_pkg::cmd_t entry_i,
  input  logic           pop_i,
  output rrts_pkg::cmd_t entry_o,
  output logic           full_o,
  output logic           empty_o
);
  import rrts_pkg::*;

  cmd_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign entry_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + QPTR_W'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + QPTR_W'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

### sv/rrts_back.sv
// back end: task table, exit and waiter memories, command execution and round-robin pick
module rrts_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             empty_i,
  input  rrts_pkg::cmd_t                   head_i,
  output logic                             pop_o,
  output logic                             done_o,
  output logic [rrts_pkg::STAT_W-1:0]      status_o,
  output logic [rrts_pkg::ID_W-1:0]        result_id_o,
  output logic                             switched_o,
  output logic [rrts_pkg::ID_W-1:0]        woken_id_o,
  output logic signed [rrts_pkg::XV_W-1:0] exit_result_o
);
  import rrts_pkg::*;

  localparam logic [1:0] BK_IDLE  = 2'd0;
  localparam logic [1:0] BK_EXEC  = 2'd1;
  localparam logic [1:0] BK_SCHED = 2'd2;

  logic [1:0]        state_q, state_d;
  cmd_t              cmd_q, cmd_d;
  logic [CNT_W-1:0]  total_q, total_d;
  logic [SLOT_W-1:0] run_q, run_d;
  logic              started_q, started_d;
  logic [STAT_W-1:0] pend_q, pend_d;

  logic [1:0]        ts_q [MAX_TASKS];
  logic [1:0]        ts_d [MAX_TASKS];

  logic [XV_W-1:0]   exit_mem [MAX_TASKS];
  logic [ID_W-1:0]   link_mem [MAX_TASKS];
  logic [XV_W-1:0]   exit_rd_q;
  logic [ID_W-1:0]   link_rd_q;
  logic              exit_we;
  logic              link_we;
  logic [SLOT_W-1:0] link_waddr;
  logic [ID_W-1:0]   link_wdata;

  logic                   done_d, done_q;
  logic [STAT_W-1:0]      st_d, st_q;
  logic [ID_W-1:0]        rid_d, rid_q;
  logic                   sw_d, sw_q;
  logic [ID_W-1:0]        wk_d, wk_q;
  logic signed [XV_W-1:0] xr_d, xr_q;

  logic [MAX_TASKS-1:0] rdy;
  logic [MAX_TASKS-1:0] above;
  logic [SLOT_W-1:0]    pick;
  logic                 id_ok;
  logic [SLOT_W-1:0]    t;
  logic [ID_W-1:0]      cur_id;
  logic [CMP_W-1:0]     par;
  logic [SLOT_W-1:0]    tot_slot;

  assign done_o        = done_q;
  assign status_o      = st_q;
  assign result_id_o   = rid_q;
  assign switched_o    = sw_q;
  assign woken_id_o    = wk_q;
  assign exit_result_o = xr_q;

  assign t        = cmd_q.slot;
  assign id_ok    = cmd_q.id_nz && (CMP_W'(cmd_q.task_id) <= CMP_W'(total_q));
  assign cur_id   = started_q ? ID_W'(CMP_W'(run_q) + CMP_W'(1)) : '0;
  assign par      = CMP_W'(link_rd_q) - CMP_W'(1);
  assign tot_slot = total_q[SLOT_W-1:0];

  always_comb begin
    for (int i = 0; i < MAX_TASKS; i++) begin
      rdy[i] = (CNT_W'(i) < total_q) &&
               ((ts_q[i] == TS_READY) ||
                ((SLOT_W'(i) == run_q) && (ts_q[i] == TS_RUNNING)));
      above[i] = (SLOT_W'(i) > run_q);
    end
    pick = (|(rdy & above)) ? first_set(rdy & above) : first_set(rdy);
  end

  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    total_d    = total_q;
    run_d      = run_q;
    started_d  = started_q;
    pend_d     = pend_q;
    ts_d       = ts_q;
    exit_we    = 1'b0;
    link_we    = 1'b0;
    link_waddr = t;
    link_wdata = '0;
    pop_o      = 1'b0;
    done_d     = 1'b0;
    st_d       = st_q;
    rid_d      = rid_q;
    sw_d       = sw_q;
    wk_d       = wk_q;
    xr_d       = xr_q;
    case (state_q)
      BK_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          cmd_d   = head_i;
          state_d = BK_EXEC;
        end
      end
      BK_EXEC: begin
        state_d = BK_IDLE;
        done_d  = 1'b1;
        st_d    = ST_OK;
        rid_d   = cur_id;
        sw_d    = 1'b0;
        wk_d    = '0;
        xr_d    = '0;
        case (cmd_q.op)
          OP_CREATE: begin
            if (total_q >= CNT_W'(MAX_TASKS)) begin
              st_d  = ST_FULL;
              rid_d = '0;
            end else begin
              ts_d[tot_slot] = TS_READY;
              link_we        = 1'b1;
              link_waddr     = tot_slot;
              link_wdata     = '0;
              total_d        = total_q + CNT_W'(1);
              rid_d          = ID_W'(CMP_W'(total_q) + CMP_W'(1));
            end
          end
          OP_START: begin
            if (total_q == '0) begin
              st_d = ST_FULL;
            end else if (!started_q) begin
              run_d     = '0;
              ts_d[0]   = TS_RUNNING;
              started_d = 1'b1;
              sw_d      = 1'b1;
              rid_d     = ID_W'(1);
            end
          end
          OP_TICK, OP_BLOCK: begin
            if (!started_q) begin
              st_d = ST_FULL;
            end else begin
              if (cmd_q.op == OP_BLOCK) ts_d[run_q] = TS_BLOCKED;
              pend_d  = ST_OK;
              done_d  = 1'b0;
              state_d = BK_SCHED;
            end
          end
          OP_WAKE: begin
            if (!id_ok) begin
              st_d = ST_NOTFOUND;
            end else if (ts_q[t] == TS_BLOCKED) begin
              ts_d[t] = TS_READY;
            end
          end
          OP_KILL: begin
            if (!id_ok || ts_q[t] == TS_TERMINATED) begin
              st_d = ST_NOTFOUND;
            end else begin
              exit_we = 1'b1;
              ts_d[t] = TS_TERMINATED;
              if (link_rd_q != '0) begin
                if ((par < CMP_W'(total_q)) && (par[SLOT_W-1:0] != t) &&
                    (ts_q[par[SLOT_W-1:0]] == TS_BLOCKED)) begin
                  ts_d[par[SLOT_W-1:0]] = TS_READY;
                end
                wk_d       = link_rd_q;
                link_we    = 1'b1;
                link_wdata = '0;
              end
            end
          end
          OP_WAIT: begin
            if (!id_ok) begin
              st_d = ST_NOTFOUND;
              xr_d = '1;
            end else if (ts_q[t] == TS_TERMINATED) begin
              xr_d = exit_rd_q;
            end else if (!started_q) begin
              st_d = ST_FULL;
            end else begin
              link_we     = 1'b1;
              link_wdata  = ID_W'(CMP_W'(run_q) + CMP_W'(1));
              ts_d[run_q] = TS_BLOCKED;
              pend_d      = ST_BLOCKED;
              done_d      = 1'b0;
              state_d     = BK_SCHED;
            end
          end
          default: begin
          end
        endcase
      end
      BK_SCHED: begin
        state_d = BK_IDLE;
        done_d  = 1'b1;
        st_d    = pend_q;
        wk_d    = '0;
        xr_d    = '0;
        sw_d    = 1'b0;
        if (|rdy) begin
          if (pick != run_q) begin
            if (ts_q[run_q] == TS_RUNNING) ts_d[run_q] = TS_READY;
            sw_d = 1'b1;
          end
          ts_d[pick] = TS_RUNNING;
          run_d      = pick;
          rid_d      = ID_W'(CMP_W'(pick) + CMP_W'(1));
        end else begin
          ts_d[run_q] = TS_RUNNING;
          rid_d       = ID_W'(CMP_W'(run_q) + CMP_W'(1));
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    ts_q <= ts_d;
    if (exit_we) begin
      exit_mem[t] <= cmd_q.exit_value;
    end
    exit_rd_q <= exit_mem[head_i.slot];
  end

  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    link_rd_q <= link_mem[head_i.slot];
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    pend_q <= pend_d;
    st_q   <= st_d;
    rid_q  <= rid_d;
    sw_q   <= sw_d;
    wk_q   <= wk_d;
    xr_q   <= xr_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_IDLE;
      total_q   <= '0;
      run_q     <= '0;
      started_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      total_q   <= total_d;
      run_q     <= run_d;
      started_q <= started_d;
      done_q    <= done_d;
    end
  end

endmodule

### sv/round_robin_task_scheduler.sv
// top level of the round-robin task scheduler
//
// channel   ports                                              handshake
// command   op_i task_id_i exit_value_i                        start_i high, busy_o low
// result    status_o result_id_o switched_o woken_id_o         done_o one-cycle strobe
//           exit_result_o
//
// a command waits in a two-item queue, then passes the back end states idle (pop
// and memory read) and execute, plus a schedule state for tick, block and a
// blocking wait (round-robin pick over all slots); results are registered
// busy_o rises only while the queue is full
// reset leaves an empty table, not started; the receiver cannot stall results
module round_robin_task_scheduler (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic [rrts_pkg::OP_W-1:0]        op_i,
  input  logic [rrts_pkg::ID_W-1:0]        task_id_i,
  input  logic signed [rrts_pkg::XV_W-1:0] exit_value_i,
  output logic                             done_o,
  output logic [rrts_pkg::STAT_W-1:0]      status_o,
  output logic [rrts_pkg::ID_W-1:0]        result_id_o,
  output logic                             switched_o,
  output logic [rrts_pkg::ID_W-1:0]        woken_id_o,
  output logic signed [rrts_pkg::XV_W-1:0] exit_result_o
);
  import rrts_pkg::*;

  cmd_t push_entry;
  cmd_t head;
  logic push;
  logic pop;
  logic full;
  logic empty;

  rrts_front u_front (
    .start_i      (start_i),
    .full_i       (full),
    .op_i         (op_i),
    .task_id_i    (task_id_i),
    .exit_value_i (exit_value_i),
    .busy_o       (busy_o),
    .push_o       (push),
    .entry_o      (push_entry)
  );

  rrts_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .entry_o (head),
    .full_o  (full),
    .empty_o (empty)
  );

  rrts_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (empty),
    .head_i        (head),
    .pop_o         (pop),
    .done_o        (done_o),
    .status_o      (status_o),
    .result_id_o   (result_id_o),
    .switched_o    (switched_o),
    .woken_id_o    (woken_id_o),
    .exit_result_o (exit_result_o)
  );

endmodule

### verif/round_robin_task_scheduler_tb.sv
`timescale 1ns / 1ps
// testbench of the round-robin task scheduler with an in-bench scheduler predictor
module round_robin_task_scheduler_tb;
  import rrts_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int SETTLE_CYCLES = 16;
  localparam int RANDOM_ITEMS = 820;
  localparam int BURST_ITEMS  = 150;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ID_W-1:0]   result_id;
    logic              switched;
    logic [ID_W-1:0]   woken_id;
    logic [XV_W-1:0]   exit_result;
  } sched_reply_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      start_i = 1'b0;
  logic                      busy_o;
  logic [OP_W-1:0]           op_i = '0;
  logic [ID_W-1:0]           task_id_i = '0;
  logic signed [XV_W-1:0]    exit_value_i = '0;
  logic                      done_o;
  logic [STAT_W-1:0]         status_o;
  logic [ID_W-1:0]           result_id_o;
  logic                      switched_o;
  logic [ID_W-1:0]           woken_id_o;
  logic signed [XV_W-1:0]    exit_result_o;

  // predictor state
  logic [1:0]      tk_state [MAX_TASKS] = '{default: '0};
  logic [XV_W-1:0] tk_exit [MAX_TASKS] = '{default: '0};
  logic [ID_W-1:0] tk_waiter [MAX_TASKS] = '{default: '0};
  int unsigned     tk_count = 0;
  int unsigned     cur_slot = 0;
  bit              sched_on = 1'b0;

  sched_reply_t reply_q [$];
  logic         busy_seen = 1'b1;
  bit           idle_on = 1'b1;
  int           error_count = 0;
  int           items_sent = 0;
  int           replies_checked = 0;
  int           op_count [8] = '{default: 0};
  int           switch_total = 0;
  int           woken_total = 0;
  int           full_total = 0;
  int           cycle_count = 0;

  round_robin_task_scheduler u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .op_i          (op_i),
    .task_id_i     (task_id_i),
    .exit_value_i  (exit_value_i),
    .done_o        (done_o),
    .status_o      (status_o),
    .result_id_o   (result_id_o),
    .switched_o    (switched_o),
    .woken_id_o    (woken_id_o),
    .exit_result_o (exit_result_o)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    busy_seen <= busy_o;
  end

  function automatic logic [ID_W-1:0] running_id();
    return sched_on ? ID_W'(cur_slot + 1) : '0;
  endfunction

  function automatic int live_tasks();
    int n;
    n = 0;
    for (int s = 0; s < int'(tk_count); s++) begin
      if (tk_state[s] != TS_TERMINATED) n++;
    end
    return n;
  endfunction

  // round-robin pick, current slot tried last
  function automatic logic pick_next();
    int unsigned from;
    int unsigned s;
    from = cur_slot;
    if (tk_count == 0 || from >= tk_count) return 1'b0;
    if (tk_state[from] == TS_RUNNING) tk_state[from] = TS_READY;
    for (int unsigned k = 1; k <= tk_count; k++) begin
      s = (from + k) % tk_count;
      if (tk_state[s] == TS_READY) begin
        cur_slot = s;
        tk_state[s] = TS_RUNNING;
        return s != from;
      end
    end
    tk_state[from] = TS_RUNNING;
    return 1'b0;
  endfunction

  function automatic sched_reply_t schedule_step(input logic [OP_W-1:0] op,
                                                 input logic [ID_W-1:0] id,
                                                 input logic [XV_W-1:0] xv);
    sched_reply_t r;
    logic         known;
    int unsigned  t;
    int unsigned  p;
    r = '0;
    known = (id != '0) && (int'(id) <= tk_count);
    t = known ? int'(id) - 1 : 0;
    case (op)
      OP_CREATE: begin
        if (tk_count >= MAX_TASKS) begin
          r.status = ST_FULL;
          full_total++;
        end else begin
          tk_state[tk_count] = TS_READY;
          tk_exit[tk_count] = '0;
          tk_waiter[tk_count] = '0;
          tk_count++;
          r.result_id = ID_W'(tk_count);
        end
      end
      OP_START: begin
        if (tk_count == 0) begin
          r.status = ST_FULL;
        end else if (!sched_on) begin
          cur_slot = 0;
          tk_state[0] = TS_RUNNING;
          sched_on = 1'b1;
          r.switched = 1'b1;
          r.result_id = ID_W'(1);
        end else begin
          r.result_id = running_id();
        end
      end
      OP_TICK, OP_BLOCK: begin
        if (!sched_on) begin
          r.status = ST_FULL;
        end else begin
          if (op == OP_BLOCK) tk_state[cur_slot] = TS_BLOCKED;
          r.switched = pick_next();
          r.result_id = running_id();
        end
      end
      OP_WAKE: begin
        if (!known) begin
          r.status = ST_NOTFOUND;
        end else if (tk_state[t] == TS_BLOCKED) begin
          tk_state[t] = TS_READY;
        end
        r.result_id = running_id();
      end
      OP_KILL: begin
        if (!known || tk_state[t] == TS_TERMINATED) begin
          r.status = ST_NOTFOUND;
        end else begin
          tk_exit[t] = xv;
          tk_state[t] = TS_TERMINATED;
          if (tk_waiter[t] != '0) begin
            p = int'(tk_waiter[t]) - 1;
            if (p < tk_count && tk_state[p] == TS_BLOCKED) tk_state[p] = TS_READY;
            r.woken_id = tk_waiter[t];
            tk_waiter[t] = '0;
            woken_total++;
          end
        end
        r.result_id = running_id();
      end
      OP_WAIT: begin
        if (!known) begin
          r.status = ST_NOTFOUND;
          r.exit_result = '1;
        end else if (tk_state[t] == TS_TERMINATED) begin
          r.exit_result = tk_exit[t];
        end else if (!sched_on) begin
          r.status = ST_FULL;
        end else begin
          tk_waiter[t] = ID_W'(cur_slot + 1);
          tk_state[cur_slot] = TS_BLOCKED;
          r.switched = pick_next();
          r.status = ST_BLOCKED;
        end
        r.result_id = running_id();
      end
      default: begin
        r.result_id = running_id();
      end
    endcase
    if (r.switched) switch_total++;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    error_count++;
    if (error_count <= 100) begin
      $display("mismatch at %0t ns: %s expected %0h got %0h", $time, what, want, got);
    end
  endtask

  always @(negedge clk_i) begin
    sched_reply_t want;
    if (rst_ni && done_o) begin
      replies_checked++;
      if (reply_q.size() == 0) begin
        report_mismatch("result with nothing pending, result_id", '0, 32'(result_id_o));
      end else begin
        want = reply_q.pop_front();
        if (status_o !== want.status)
          report_mismatch("status", 32'(want.status), 32'(status_o));
        if (result_id_o !== want.result_id)
          report_mismatch("result_id", 32'(want.result_id), 32'(result_id_o));
        if (switched_o !== want.switched)
          report_mismatch("switched", 32'(want.switched), 32'(switched_o));
        if (woken_id_o !== want.woken_id)
          report_mismatch("woken_id", 32'(want.woken_id), 32'(woken_id_o));
        if (exit_result_o !== want.exit_result)
          report_mismatch("exit_result", want.exit_result, exit_result_o);
      end
    end
  end

  task automatic send_cmd(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                          input logic [XV_W-1:0] xv);
    start_i <= 1'b1;
    op_i <= op;
    task_id_i <= id;
    exit_value_i <= xv;
    @(posedge clk_i);
    while (busy_seen) @(posedge clk_i);
    reply_q.push_back(schedule_step(op, id, xv));
    items_sent++;
    op_count[op]++;
  endtask

  // random idle burst, with junk on the fields while start is low
  task automatic maybe_idle();
    int n;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 9);
      start_i <= 1'b0;
      op_i <= OP_W'($urandom());
      task_id_i <= ID_W'($urandom());
      exit_value_i <= $urandom();
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic wait_all_replies();
    start_i <= 1'b0;
    do @(posedge clk_i); while (reply_q.size() != 0);
  endtask

  task automatic send_item(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                           input logic [XV_W-1:0] xv);
    maybe_idle();
    send_cmd(op, id, xv);
  endtask

  function automatic logic [XV_W-1:0] pick_exit();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return 32'h8000_0000;
      3: return 32'h7fff_ffff;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [ID_W-1:0] pick_target();
    if (tk_count == 0 || $urandom_range(0, 4) == 0) return ID_W'($urandom_range(0, 16));
    return ID_W'($urandom_range(1, tk_count));
  endfunction

  task automatic test_before_start();
    send_item(OP_START, '0, '0);
    send_item(OP_TICK, '0, '0);
    send_item(OP_BLOCK, '0, '0);
    send_item(OP_WAKE, '0, '0);
    send_item(OP_KILL, ID_W'(1), '1);
    send_item(OP_WAIT, ID_W'(16), '0);
    send_item(OP_UNUSED, ID_W'(31), '1);
  endtask

  task automatic test_create_and_start();
    repeat (4) send_item(OP_CREATE, '0, '0);
    send_item(OP_WAIT, ID_W'(2), '0);
    send_item(OP_START, '0, '0);
    send_item(OP_START, '0, '0);
    send_item(OP_TICK, '0, '0);
  endtask

  task automatic test_block_and_wake();
    send_item(OP_BLOCK, '0, '0);
    send_item(OP_WAKE, ID_W'(2), '0);
    send_item(OP_WAKE, ID_W'(4), '0);
    send_item(OP_WAKE, ID_W'(16), '0);
  endtask

  task automatic test_wait_and_kill();
    wait_all_replies();
    send_item(OP_WAIT, ID_W'(1), '0);
    send_item(OP_WAKE, ID_W'(3), '0);
    send_item(OP_KILL, ID_W'(1), 32'h8000_0000);
    send_item(OP_WAIT, ID_W'(1), '0);
    send_item(OP_KILL, ID_W'(1), '0);
    send_item(OP_KILL, running_id(), 32'h7fff_ffff);
    send_item(OP_TICK, '0, '0);
  endtask

  // wait on a target, let the ring turn, maybe wake a task, kill the target, collect its exit code
  task automatic send_wait_kill_sequence();
    logic [ID_W-1:0] target;
    target = ID_W'($urandom_range(1, tk_count));
    send_item(OP_WAIT, target, '0);
    repeat ($urandom_range(0, 3)) send_item(OP_TICK, '0, '0);
    if ($urandom_range(0, 1) == 0) send_item(OP_WAKE, pick_target(), '0);
    send_item(OP_KILL, target, pick_exit());
    send_item(OP_WAIT, target, '0);
  endtask

  task automatic send_random_cmd();
    int              r;
    logic [OP_W-1:0] op;
    r = $urandom_range(0, 99);
    if (r < 6) op = OP_CREATE;
    else if (r < 9) op = OP_START;
    else if (r < 40) op = OP_TICK;
    else if (r < 52) op = OP_BLOCK;
    else if (r < 72) op = OP_WAKE;
    else if (r < 76) op = OP_KILL;
    else if (r < 99) op = OP_WAIT;
    else op = OP_UNUSED;
    // keep part of the ring alive so scheduling stays interesting
    if (op == OP_KILL && live_tasks() <= 2) op = OP_WAKE;
    send_item(op, pick_target(), pick_exit());
  endtask

  task automatic test_random_mix();
    int first;
    int chunk_mark;
    first = items_sent;
    chunk_mark = items_sent;
    while (items_sent - first < RANDOM_ITEMS) begin
      if (items_sent - chunk_mark >= 100) begin
        chunk_mark = items_sent;
        idle_on = ($urandom_range(0, 2) != 0);
        if ($urandom_range(0, 2) == 0) wait_all_replies();
      end
      if (sched_on && live_tasks() > 4 && $urandom_range(0, 19) == 0) begin
        send_wait_kill_sequence();
      end else begin
        send_random_cmd();
      end
    end
  endtask

  task automatic test_back_to_back();
    idle_on = 1'b0;
    repeat (BURST_ITEMS) send_random_cmd();
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_before_start();
    test_create_and_start();
    test_block_and_wake();
    test_wait_and_kill();
    test_random_mix();
    test_back_to_back();
    wait_all_replies();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("covered %0d commands: %0d create, %0d tick, %0d block, %0d wake, %0d kill, %0d wait",
             items_sent, op_count[OP_CREATE], op_count[OP_TICK], op_count[OP_BLOCK],
             op_count[OP_WAKE], op_count[OP_KILL], op_count[OP_WAIT]);
    $display("%0d results checked, %0d switches, %0d parents woken by kill, %0d creates on full",
             replies_checked, switch_total, woken_total, full_total);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### files.f
sv/rrts_pkg.sv
sv/rrts_front.sv
sv/rrts_queue.sv
sv/rrts_back.sv
sv/round_robin_task_scheduler.sv
verif/round_robin_task_scheduler_tb.sv
